### src/bate_pkg.sv
`timescale 1ns / 1ps
// Package for the block allocation table engine: word types, codes, command and
// status structs shared by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package bate_pkg;

    localparam int DEF_MAX_BLOCKS = 4096;

    // Widths fixed by the word layout
    localparam int CFG_W       = 13;
    localparam int CFG_IW      = 1;
    localparam int IDX_W       = 12;
    localparam int LINK_W      = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_BLOCK_COUNT    = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_RESERVED_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_COUNT_RST = 13'd0;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINK   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Table words
    localparam logic [LINK_W-1:0] RESERVED_MARK = 32'h8FFF_FFFF;
    localparam logic [LINK_W-1:0] END_OF_CHAIN  = 32'hFFFF_FFFF;
    localparam logic [LINK_W-1:0] FREE_WORD     = 32'h0000_0000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  block_index;
        logic [LINK_W-1:0] link_value;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    found_index;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FORMAT,
        S_SCAN,
        S_LINK,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                fmt_write;
        logic                scan_read;
        logic                alloc_write;
        logic                link_write;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_found;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              fmt_done;
        logic              scan_hit;
        logic              scan_exhausted;
        logic              link_in_range;
    } sts_t;

endpackage

### src/block_allocation_table_engine.sv
`timescale 1ns / 1ps
// Block allocation table engine: first-fit allocator over a one-word-per-block table.
// Depends on bate_pkg, bate_ctrl and bate_datapath.
//
// Usage:
//   Raise start with an item word on item; it is taken at the edge where busy is
//   low. busy stays high until the result has been shown. The result word is marked
//   on result by done, high for exactly one cycle; the receiver cannot stall it.
//   Configuration (block_count at index 0, reserved_count at index 1) is written
//   through cfg_wr_en / cfg_index / cfg_data by the user only while the engine is
//   idle; the block itself does not enforce this.
// With N the entries in use (min of block_count and MAX_BLOCKS):
//   format   : writes the N entries one per cycle through the table memory port.
//   allocate : scans from index 0 for the first free entry, or reports full when
//              none of the N is free; the scan reads one entry per cycle through
//              the registered memory read port.
//   link     : writes when block_index is below N, else range.  unused mode: ok.
//   One item at a time; the next is taken the cycle after done.
// Reset clears the controller, configuration registers and scan counter; table
// contents are undefined until format or link writes them, so format the table first.
module block_allocation_table_engine
    import bate_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_wr_en,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic busy_int;

    // Accept only while idle
    bate_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy_int),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy_int),
        .done  (done)
    );

    bate_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

    assign busy = busy_int;

endmodule

### src/bate_ctrl.sv
`timescale 1ns / 1ps
// Controller of the block allocation table engine: sequences format, scan and link.
// Depends on bate_pkg.
module bate_ctrl
    import bate_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  sts_t   sts,
    output cmd_t   cmd,
    output logic   busy,
    output logic   done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_FORMAT: state_next = S_FORMAT;
                    MODE_ALLOC:  state_next = S_SCAN;
                    MODE_LINK:   state_next = S_LINK;
                    default:     state_next = S_DONE;
                endcase
            end
            S_FORMAT:
            begin
                if (sts.fmt_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_hit || sts.scan_exhausted)
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK:  state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DISPATCH:
            begin
                // Unused mode: answer ok with a zero index
                if (sts.mode != MODE_FORMAT && sts.mode != MODE_ALLOC
                    && sts.mode != MODE_LINK)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                end
            end
            S_FORMAT:
            begin
                if (sts.fmt_done)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                end
                else
                begin
                    cmd.fmt_write = 1'b1;
                end
            end
            S_SCAN:
            begin
                priority if (sts.scan_hit)
                begin
                    cmd.alloc_write = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res_status  = ST_OK;
                    cmd.res_found   = 1'b1;
                end
                else if (sts.scan_exhausted)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                end
            end
            S_LINK:
            begin
                cmd.res_load   = 1'b1;
                cmd.link_write = sts.link_in_range;
                cmd.res_status = sts.link_in_range ? ST_OK : ST_RANGE;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/bate_datapath.sv
`timescale 1ns / 1ps
// Datapath of the block allocation table engine: configuration registers, table
// memory, entry counter, scan pipeline and result register. Depends on bate_pkg.
module bate_datapath
    import bate_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  item_t             item,
    input  cmd_t              cmd,
    output sts_t              sts,
    output result_t           result
);

    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam int IW   = (AW > IDX_W) ? AW : IDX_W;
    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_BLOCKS);

    logic [CFG_W-1:0]  block_count_reg;
    logic [CFG_W-1:0]  reserved_count_reg;
    item_t             item_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [AW-1:0]     rd_idx_reg;
    logic [LINK_W-1:0] rdata_reg;
    result_t           result_reg;
    result_t           result_next;

    logic [LINK_W-1:0] mem [MAX_BLOCKS];

    logic [CMPW-1:0]   used;
    logic [CMPW-1:0]   bc_w;
    logic [CMPW-1:0]   cnt_w;
    logic [CMPW-1:0]   link_w;
    logic [IW-1:0]     link_idx_w;
    logic [IW-1:0]     found_w;
    logic [AW-1:0]     cnt_addr;
    logic              cnt_in_use;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LINK_W-1:0] wr_word;

    // Entries in use: the smaller of block_count and the table depth
    assign bc_w       = CMPW'(block_count_reg);
    assign used       = (bc_w < MAX_C) ? bc_w : MAX_C;
    assign cnt_w      = CMPW'(cnt_reg);
    assign cnt_addr   = cnt_reg[AW-1:0];
    assign cnt_in_use = (cnt_w < used);
    assign link_w     = CMPW'(item_reg.block_index);
    assign link_idx_w = IW'(item_reg.block_index);
    assign found_w    = IW'(rd_idx_reg);

    assign sts.mode           = item_reg.mode;
    assign sts.fmt_done       = !cnt_in_use;
    assign sts.scan_hit       = rd_valid_reg && (rdata_reg == FREE_WORD);
    assign sts.scan_exhausted = !rd_valid_reg && !cnt_in_use;
    assign sts.link_in_range  = (link_w < used);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg    <= BLOCK_COUNT_RST;
            reserved_count_reg <= RESERVED_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BLOCK_COUNT:    block_count_reg    <= cfg_data;
                CFG_RESERVED_COUNT: reserved_count_reg <= cfg_data;
                default:            block_count_reg    <= block_count_reg;
            endcase
        end
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        rd_valid_next = rd_valid_reg;
        if (cmd.load)
        begin
            cnt_next      = '0;
            rd_valid_next = 1'b0;
        end
        else if (cmd.fmt_write)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.scan_read)
        begin
            rd_valid_next = cnt_in_use;
            if (cnt_in_use)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.scan_read)
        begin
            rd_idx_reg <= cnt_addr;
        end
        result_reg <= result_next;
    end

    // One write port: format sweep, allocation mark or link word
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_addr;
        wr_word = FREE_WORD;
        priority if (cmd.fmt_write)
        begin
            wr_en   = 1'b1;
            wr_word = (cnt_w < CMPW'(reserved_count_reg)) ? RESERVED_MARK : FREE_WORD;
        end
        else if (cmd.alloc_write)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_word = END_OF_CHAIN;
        end
        else if (cmd.link_write)
        begin
            wr_en   = 1'b1;
            wr_addr = link_idx_w[AW-1:0];
            wr_word = item_reg.link_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (cmd.scan_read)
        begin
            rdata_reg <= mem[cnt_addr];
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.res_load)
        begin
            result_next.status      = cmd.res_status;
            result_next.found_index = cmd.res_found ? found_w[IDX_W-1:0] : '0;
        end
    end

    assign result = result_reg;

endmodule

### src/bate_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the block allocation table engine, with its bind.
// Depends on bate_pkg and block_allocation_table_engine.
module bate_checker
    import bate_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // An accepted word makes the engine busy
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("engine not busy after accepting a word");

    // A result only appears while a word is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");

    // Strobe lasts one cycle and the engine is free right after it
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("result strobe held or engine still busy after result");

    // Full table and out-of-range links report a zero index; status stays within its codes
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.found_index == '0)
        else $error("non-zero index on a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_FULL
                  || result.status == ST_RANGE))
        else $error("undefined status code");

endmodule

bind block_allocation_table_engine bate_checker u_bate_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### dv/bate_tb_pkg.sv
`timescale 1ns / 1ps
// Checker package for the allocation table engine bench: a scoreboard class that mirrors
// the table and queues the result words still owed by the engine. Depends on bate_pkg.
package bate_tb_pkg;
    import bate_pkg::*;

    class alloc_table_book;
        logic [LINK_W-1:0] entry_word [DEF_MAX_BLOCKS];
        bit                written [DEF_MAX_BLOCKS];
        int                block_count;
        int                reserved_count;
        result_t           owed_q [$];
        int                errors;

        function new();
            for (int i = 0; i < DEF_MAX_BLOCKS; i++)
            begin
                entry_word[i] = FREE_WORD;
                written[i]    = 1'b0;
            end
            block_count    = int'(BLOCK_COUNT_RST);
            reserved_count = int'(RESERVED_COUNT_RST);
            errors         = 0;
        endfunction

        function int entries_in_use();
            return (block_count < DEF_MAX_BLOCKS) ? block_count : DEF_MAX_BLOCKS;
        endfunction

        function void set_register(logic [CFG_IW-1:0] index, logic [CFG_W-1:0] value);
            if (index == CFG_BLOCK_COUNT)
                block_count = int'(value);
            else
                reserved_count = int'(value);
        endfunction

        // A first-fit scan may only touch entries that have been written
        function bit scan_is_safe();
            int used;
            used = entries_in_use();
            for (int i = 0; i < used; i++)
            begin
                if (!written[i])
                    return 1'b0;
                if (entry_word[i] == FREE_WORD)
                    return 1'b1;
            end
            return 1'b1;
        endfunction

        // Apply an accepted word to the mirror and queue the result it owes
        function void note_item(item_t word_in);
            result_t want;
            int      used;
            bit      hit;
            used             = entries_in_use();
            want.status      = ST_OK;
            want.found_index = '0;
            hit              = 1'b0;
            case (word_in.mode)
                MODE_FORMAT:
                    for (int i = 0; i < used; i++)
                    begin
                        entry_word[i] = (i < reserved_count) ? RESERVED_MARK : FREE_WORD;
                        written[i]    = 1'b1;
                    end
                MODE_ALLOC:
                begin
                    want.status = ST_FULL;
                    for (int i = 0; i < used && !hit; i++)
                    begin
                        if (entry_word[i] == FREE_WORD)
                        begin
                            entry_word[i]    = END_OF_CHAIN;
                            want.status      = ST_OK;
                            want.found_index = IDX_W'(i);
                            hit              = 1'b1;
                        end
                    end
                end
                MODE_LINK:
                    if (int'(word_in.block_index) < used)
                    begin
                        entry_word[word_in.block_index] = word_in.link_value;
                        written[word_in.block_index]    = 1'b1;
                    end
                    else
                    begin
                        want.status = ST_RANGE;
                    end
                default: ;
            endcase
            owed_q.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result word: status %0d found_index %0d",
                       got.status, got.found_index);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.found_index !== want.found_index)
            begin
                $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

endpackage

### dv/tb_block_allocation_table_engine.sv
`timescale 1ns / 1ps
// Bench for the block allocation table engine: directed and random command words checked
// against a mirrored allocation table. Depends on bate_pkg, bate_tb_pkg and the engine RTL.
module tb_block_allocation_table_engine;
    import bate_pkg::*;
    import bate_tb_pkg::*;

    // Slowest word is a full scan of the largest table; allow several of those back to back
    localparam int                WATCHDOG_LIMIT = 4 * (DEF_MAX_BLOCKS + 5) + 400;
    localparam int                ITEM_TARGET    = 140;
    localparam int                CFG_MAX        = (1 << CFG_W) - 1;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              done;
    result_t           result;
    logic              cfg_wr_en;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    alloc_table_book   book;
    int                words_sent;
    int unsigned       gap_pct;
    int                quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    block_allocation_table_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Result words last one cycle and cannot be stalled: take each one at the edge that
    // closes its cycle, reading the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_result(result);
    end

    // Count cycles in which no word moves either way; give up once the count is
    // well past the longest legal scan.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_block_allocation_table_engine failed");
            $finish;
        end
    end

    // Offer one command word and hold it until the engine takes it. The sender's idle
    // rate steps from moderate to heavy to none over the run.
    task automatic send_word(input item_t word_out);
        gap_pct = (words_sent < ITEM_TARGET / 3)     ? 31 :
                  (words_sent < 2 * ITEM_TARGET / 3) ? 87 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= word_out;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_item(word_out);
        words_sent++;
    endtask

    task automatic issue(input logic [MODE_W-1:0] mode, input int index,
                         input logic [LINK_W-1:0] value);
        item_t w;
        w.mode        = mode;
        w.block_index = IDX_W'(index);
        w.link_value  = value;
        send_word(w);
    endtask

    // Drop start and wait until every owed result has come back and the engine is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0 || busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write both registers on consecutive edges, keeping the write enable high between them
    task automatic load_config(input int blocks, input int reserved);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data  <= CFG_W'(blocks);
        @(posedge clk);
        cfg_index <= CFG_RESERVED_COUNT;
        cfg_data  <= CFG_W'(reserved);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.set_register(CFG_BLOCK_COUNT, CFG_W'(blocks));
        book.set_register(CFG_RESERVED_COUNT, CFG_W'(reserved));
    endtask

    // Mostly allocate and in-range link words; links often free an entry again so that
    // allocation keeps finding space. An allocate that would read a never-written entry
    // is turned into a format.
    function automatic item_t pick_word();
        item_t       w;
        int          used;
        int unsigned roll;
        used          = book.entries_in_use();
        roll          = $urandom_range(99);
        w.mode        = MODE_ALLOC;
        w.block_index = IDX_W'($urandom_range(DEF_MAX_BLOCKS - 1));
        w.link_value  = $urandom();
        if (roll < 38)
            w.mode = MODE_ALLOC;
        else if (roll < 72)
        begin
            w.mode = MODE_LINK;
            if (used > 0)
                w.block_index = IDX_W'($urandom_range(used - 1));
            case ($urandom_range(3))
                0, 1:    w.link_value = FREE_WORD;
                2:       w.link_value = END_OF_CHAIN;
                default: ;
            endcase
        end
        else if (roll < 80)
            w.mode = MODE_FORMAT;
        else if (roll < 92)
        begin
            w.mode = MODE_LINK;
            if (used < DEF_MAX_BLOCKS)
                w.block_index = IDX_W'($urandom_range(DEF_MAX_BLOCKS - 1, used));
        end
        else
            w.mode = MODE_UNUSED;
        if (w.mode == MODE_ALLOC && !book.scan_is_safe())
            w.mode = MODE_FORMAT;
        return w;
    endfunction

    // One random setting of the registers followed by a run of words. Small tables
    // dominate so that scans stay short; a few large ones still appear.
    task automatic random_phase();
        int          blocks;
        int          reserved;
        int          count;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            blocks = $urandom_range(40, 1);
        else if (roll < 78)
            blocks = 0;
        else if (roll < 92)
            blocks = $urandom_range(300, 41);
        else
            blocks = ($urandom_range(1) == 0) ? DEF_MAX_BLOCKS : CFG_MAX;
        roll = $urandom_range(99);
        if (roll < 45)
            reserved = $urandom_range((blocks < 8) ? blocks : 8);
        else if (roll < 65)
            reserved = 0;
        else if (roll < 85)
            reserved = $urandom_range(blocks + 4);
        else if (roll < 93)
            reserved = blocks;
        else
            reserved = CFG_MAX;
        if (reserved > CFG_MAX)
            reserved = CFG_MAX;
        count = $urandom_range(16, 8);
        settle();
        load_config(blocks, reserved);
        if ($urandom_range(4) != 0)
            issue(MODE_FORMAT, 0, FREE_WORD);
        for (int k = 0; k < count && words_sent < ITEM_TARGET; k++)
            send_word(pick_word());
    endtask

    initial
    begin
        book       = new();
        words_sent = 0;
        gap_pct    = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Small table with three reserved entries: first-fit order, links inside, just
        // past and far past the end, and the unused mode.
        settle();
        load_config(16, 3);
        issue(MODE_FORMAT, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_LINK, 4, 32'd5);
        issue(MODE_LINK, 15, FREE_WORD);
        issue(MODE_LINK, 16, 32'h1234_5678);
        issue(MODE_LINK, DEF_MAX_BLOCKS - 1, END_OF_CHAIN);
        issue(MODE_UNUSED, $urandom_range(DEF_MAX_BLOCKS - 1), $urandom());
        issue(MODE_ALLOC, 0, FREE_WORD);

        // Format a shorter table, then widen it: the entries beyond the short format
        // must keep what they held, so allocation skips the chained ones.
        settle();
        load_config(4, 3);
        issue(MODE_FORMAT, 0, FREE_WORD);
        settle();
        load_config(16, 3);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);

        // Empty table: format writes nothing, allocation is full, every link out of range
        settle();
        load_config(0, 0);
        issue(MODE_FORMAT, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_LINK, 0, END_OF_CHAIN);

        // Reserved count past the block count: every entry in use ends up reserved
        settle();
        load_config(5, CFG_MAX);
        issue(MODE_FORMAT, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);

        // Oversized block count clips to the table size; only the last entry is free,
        // so the scans run the whole table and the found index reaches all ones.
        settle();
        load_config(CFG_MAX, DEF_MAX_BLOCKS - 1);
        issue(MODE_FORMAT, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_LINK, DEF_MAX_BLOCKS - 1, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);
        issue(MODE_LINK, 0, FREE_WORD);
        issue(MODE_ALLOC, 0, FREE_WORD);

        while (words_sent < ITEM_TARGET)
            random_phase();

        // Drain, then hold a little longer to catch any stray result word
        start <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (book.errors == 0 && book.pending() == 0)
            $display("tb_block_allocation_table_engine passed");
        else
            $display("tb_block_allocation_table_engine failed");
        $finish;
    end

endmodule
